// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

  // input beat: one message byte with its marks
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       is_last;
  } msg_t;

  // output beat: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  // command codes passed from the front to the back
  localparam logic [1:0] OP_DATA      = 2'd0;
  localparam logic [1:0] OP_DATA_LAST = 2'd1;
  localparam logic [1:0] OP_LAST      = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  // command queue geometry, depth is a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// ===== rtl/sha1_hash_engine.sv =====
// channel | beat     | handshake                  | content
// msg     | msg_t    | msg_valid / msg_ready      | one byte with has_byte and is_last marks
// digest  | digest_t | digest_valid / digest_ready| one digest word, index 0..4, last mark
//
// a data beat is merged into the block window while the back end is idle; a full 64-byte block
// then runs 80 rounds at one per cycle, followed by the chaining add
// a last beat adds padding (pad byte, zero words, length words), one or two compressions, and 5 digest beats
// a two-entry command queue lets the front keep taking beats while the back compresses
// rst is synchronous active high and restores the initial chaining value and counters
// digest beats sit in an output register; a stalled digest holds the back end,
// and the front as well once the queue is full
module sha1_hash_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_ready,
  input  sha1_pkg::msg_t    msg,
  output logic              digest_valid,
  input  logic              digest_ready,
  output sha1_pkg::digest_t digest
);

  // front to queue
  logic           q_push;
  sha1_pkg::cmd_t q_cmd;
  logic           q_full;

  // queue to back
  logic           q_pop;
  sha1_pkg::cmd_t q_head;
  logic           q_empty;

  // front: classify beats, drop idle ones
  sha1_front u_front (
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // decoupling queue between the byte front and the compression back
  sha1_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: packing, padding, 80-round compression, digest output
  sha1_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (q_head),
    .cmd_empty    (q_empty),
    .cmd_pop      (q_pop),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

endmodule

// ===== rtl/sha1_front.sv =====
module sha1_front (
  input  logic              msg_valid,
  output logic              msg_ready,
  input  sha1_pkg::msg_t    msg,
  input  logic              q_full,
  output logic              q_push,
  output sha1_pkg::cmd_t    q_cmd
);

  logic keep;

  // classify the beat; beats with neither a byte nor an end mark are dropped
  always_comb begin
    keep       = 1'b1;
    q_cmd.data = msg.msg_byte;
    unique case ({msg.has_byte, msg.is_last})
      2'b10:   q_cmd.op = sha1_pkg::OP_DATA;
      2'b11:   q_cmd.op = sha1_pkg::OP_DATA_LAST;
      2'b01:   q_cmd.op = sha1_pkg::OP_LAST;
      default: begin
        q_cmd.op = sha1_pkg::OP_DATA;
        keep     = 1'b0;
      end
    endcase
  end

  assign msg_ready = !q_full;
  assign q_push    = msg_valid && !q_full && keep;

endmodule

// ===== rtl/sha1_queue.sv =====
module sha1_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sha1_pkg::cmd_t push_cmd,
  input  logic           pop,
  output sha1_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);

  sha1_pkg::cmd_t                  mem [sha1_pkg::Q_DEPTH];
  logic [sha1_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [sha1_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [sha1_pkg::Q_CNT_W-1:0]    count;

  assign full    = (count == sha1_pkg::Q_CNT_W'(sha1_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sha1_back.sv =====
module sha1_back (
  input  logic              clk,
  input  logic              rst,
  input  sha1_pkg::cmd_t    cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output logic              digest_valid,
  input  logic              digest_ready,
  output sha1_pkg::digest_t digest
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD    = 3'd1;
  localparam logic [2:0] S_ZERO   = 3'd2;
  localparam logic [2:0] S_LEN_HI = 3'd3;
  localparam logic [2:0] S_LEN_LO = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  localparam logic [6:0] LAST_ROUND = 7'd79;

  function automatic logic [31:0] merge_byte(input logic [31:0] word, input logic [1:0] pos,
                                             input logic [7:0] val);
    logic [31:0] placed;
    placed = {24'd0, val} << {~pos, 3'b000};
    return (pos == 2'd0) ? placed : (word | placed);
  endfunction

  logic [2:0]  state;
  logic [2:0]  ret;
  logic [6:0]  rnd;
  logic [3:0]  wcnt;
  logic [1:0]  pcnt;
  logic [31:0] pword;
  logic [63:0] bitlen;
  logic [2:0]  emit_idx;
  logic [31:0] h [5];
  logic [31:0] v [5];
  logic [31:0] w [16];

  logic        is_data;
  logic        is_end;
  logic [31:0] merged;
  logic        push_en;
  logic [31:0] push_val;
  logic        full;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] tmp;
  logic [31:0] w_mix;
  logic [31:0] w_new;

  assign cmd_pop = (state == S_IDLE) && !cmd_empty;

  always_comb begin
    is_data = 1'b0;
    is_end  = 1'b0;
    unique case (cmd.op)
      sha1_pkg::OP_DATA:      is_data = 1'b1;
      sha1_pkg::OP_DATA_LAST: begin
        is_data = 1'b1;
        is_end  = 1'b1;
      end
      sha1_pkg::OP_LAST:      is_end = 1'b1;
      default: ;
    endcase
  end

  // word pushes into the block window
  always_comb begin
    merged   = merge_byte(pword, pcnt, cmd.data);
    push_en  = 1'b0;
    push_val = merged;
    case (state)
      S_IDLE:   push_en = cmd_pop && is_data && (pcnt == 2'd3);
      S_PAD: begin
        push_en  = 1'b1;
        push_val = merge_byte(pword, pcnt, sha1_pkg::PAD_BYTE);
      end
      S_ZERO: begin
        push_en  = (wcnt != 4'd14);
        push_val = '0;
      end
      S_LEN_HI: begin
        push_en  = 1'b1;
        push_val = bitlen[63:32];
      end
      S_LEN_LO: begin
        push_en  = 1'b1;
        push_val = bitlen[31:0];
      end
      default: ;
    endcase
  end

  assign full = push_en && (wcnt == 4'hf);

  // one compression round
  always_comb begin
    if (rnd < 7'd20) begin
      f = (v[1] & v[2]) | (~v[1] & v[3]);
      k = sha1_pkg::K_R0;
    end else if (rnd < 7'd40) begin
      f = v[1] ^ v[2] ^ v[3];
      k = sha1_pkg::K_R1;
    end else if (rnd < 7'd60) begin
      f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
      k = sha1_pkg::K_R2;
    end else begin
      f = v[1] ^ v[2] ^ v[3];
      k = sha1_pkg::K_R3;
    end
    tmp   = {v[0][26:0], v[0][31:27]} + f + v[4] + k + w[0];
    w_mix = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      rnd          <= '0;
      wcnt         <= '0;
      pcnt         <= '0;
      bitlen       <= '0;
      emit_idx     <= '0;
      digest_valid <= 1'b0;
      h            <= sha1_pkg::H_INIT;
    end else begin
      if ((state == S_EMIT) && (!digest_valid || digest_ready)) begin
        digest_valid <= 1'b1;
      end else if (digest_ready) begin
        digest_valid <= 1'b0;
      end
      if (push_en) begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= push_val;
        wcnt  <= wcnt + 1'b1;
      end
      if (full) begin
        v     <= h;
        state <= S_ROUND;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            if (is_data) begin
              pword  <= merged;
              pcnt   <= pcnt + 1'b1;
              bitlen <= bitlen + 64'd8;
            end
            if (full) begin
              ret <= is_end ? S_PAD : S_IDLE;
            end else if (is_end) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pcnt <= '0;
          ret  <= S_ZERO;
          if (!full) begin
            state <= S_ZERO;
          end
        end
        S_ZERO: begin
          ret <= S_ZERO;
          if (wcnt == 4'd14) begin
            state <= S_LEN_HI;
          end
        end
        S_LEN_HI: state <= S_LEN_LO;
        S_LEN_LO: ret <= S_EMIT;
        S_ROUND: begin
          v[0] <= tmp;
          v[1] <= v[0];
          v[2] <= {v[1][1:0], v[1][31:2]};
          v[3] <= v[2];
          v[4] <= v[3];
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_new;
          if (rnd == LAST_ROUND) begin
            rnd   <= '0;
            state <= S_ADD;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 5; i++) begin
            h[i] <= h[i] + v[i];
          end
          state <= ret;
        end
        S_EMIT: begin
          if (!digest_valid || digest_ready) begin
            digest.digest_word <= h[0];
            digest.word_index  <= emit_idx;
            digest.last_word   <= (emit_idx == 3'd4);
            if (emit_idx == 3'd4) begin
              emit_idx <= '0;
              h        <= sha1_pkg::H_INIT;
              bitlen   <= '0;
              wcnt     <= '0;
              pcnt     <= '0;
              state    <= S_IDLE;
            end else begin
              for (int i = 0; i < 4; i++) begin
                h[i] <= h[i+1];
              end
              h[4]     <= h[0];
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (rst) rnd <= LAST_ROUND)
    else $error("round counter out of range");

  a_rnd_only_in_round: assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND) |-> (rnd == '0))
    else $error("round counter moved outside compression");

  a_digest_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(digest_valid) |-> ($past(state) == S_EMIT))
    else $error("digest beat raised outside emit");

  a_last_word_index: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest.last_word == (digest.word_index == 3'd4)))
    else $error("last word mark disagrees with index");

endmodule
